>>> src/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers, compiled out when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define B64E_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define B64E_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define B64E_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define B64E_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> src/b64e_pkg.sv
// ---------------------------------------------------------------------------
// Base64 encoder package
// Shared types, constants and the symbol-to-ASCII mapping.
// ---------------------------------------------------------------------------
`default_nettype none

package b64e_pkg;

    localparam logic [7:0] CHAR_PAD   = 8'h3D;
    localparam logic [7:0] CHAR_UPPER = 8'h41;
    localparam logic [7:0] CHAR_LOWER = 8'h61;
    localparam logic [7:0] CHAR_DIGIT = 8'h30;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = 1;
    localparam int QUEUE_CW    = 2;

    typedef enum logic [1:0] {
        PH_0 = 2'd0,
        PH_1 = 2'd1,
        PH_2 = 2'd2
    } t_phase;

    typedef struct packed {
        logic       pad;
        logic [5:0] idx;
    } t_sym;

    typedef struct packed {
        t_sym [3:0] syms;
        logic [1:0] last;
        logic       fin;
    } t_job;

    function automatic logic [7:0] sym_to_ascii(input t_sym s);
        logic [7:0] v;
        v = {2'b00, s.idx};
        if (s.pad) begin
            return CHAR_PAD;
        end else if (s.idx < 6'd26) begin
            return CHAR_UPPER + v;
        end else if (s.idx < 6'd52) begin
            return CHAR_LOWER + v - 8'd26;
        end else if (s.idx < 6'd62) begin
            return CHAR_DIGIT + v - 8'd52;
        end else if (s.idx == 6'd62) begin
            return CHAR_PLUS;
        end else begin
            return CHAR_SLASH;
        end
    endfunction

endpackage

`default_nettype wire

>>> src/b64e_front.sv
// ---------------------------------------------------------------------------
// Base64 encoder front end
// Tracks group phase and leftover bits, turns each byte into a symbol job.
// ---------------------------------------------------------------------------
`default_nettype none

module b64e_front
    import b64e_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_accept,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_final_byte,
    output t_job            o_job
);

    t_phase     r_phase, n_phase;
    logic [3:0] r_left,  n_left;
    t_job       job;

    always_comb begin
        job      = '0;
        job.fin  = i_final_byte;
        n_phase  = r_phase;
        n_left   = r_left;
        case (r_phase)
            PH_1: begin
                job.syms[0].idx = {r_left[1:0], i_data_byte[7:4]};
                if (i_final_byte) begin
                    job.syms[1].idx = {i_data_byte[3:0], 2'b00};
                    job.syms[2].pad = 1'b1;
                    job.last        = 2'd2;
                end else begin
                    job.last = 2'd0;
                    n_left   = i_data_byte[3:0];
                    n_phase  = PH_2;
                end
            end
            PH_2: begin
                job.syms[0].idx = {r_left, i_data_byte[7:6]};
                job.syms[1].idx = i_data_byte[5:0];
                job.last        = 2'd1;
                n_left          = 4'd0;
                n_phase         = PH_0;
            end
            default: begin
                job.syms[0].idx = i_data_byte[7:2];
                if (i_final_byte) begin
                    job.syms[1].idx = {i_data_byte[1:0], 4'b0000};
                    job.syms[2].pad = 1'b1;
                    job.syms[3].pad = 1'b1;
                    job.last        = 2'd3;
                end else begin
                    job.last = 2'd0;
                    n_left   = {2'b00, i_data_byte[1:0]};
                    n_phase  = PH_1;
                end
            end
        endcase
        if (i_final_byte) begin
            n_phase = PH_0;
            n_left  = 4'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_0;
            r_left  <= 4'd0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_left  <= n_left;
        end
    end

    assign o_job = job;

endmodule

`default_nettype wire

>>> src/b64e_queue.sv
// ---------------------------------------------------------------------------
// Base64 encoder job queue
// Short FIFO between front end and character serialiser.
// ---------------------------------------------------------------------------
`default_nettype none

module b64e_queue
    import b64e_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_job      i_job,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_valid,
    output t_job      o_job
);

    t_job                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wptr,  n_wptr;
    logic [QUEUE_AW-1:0] r_rptr,  n_rptr;
    logic [QUEUE_CW-1:0] r_count, n_count;
    logic                do_push, do_pop;

    always_comb begin
        o_full  = (r_count == QUEUE_CW'(QUEUE_DEPTH));
        o_valid = (r_count != '0);
        do_push = i_push && !o_full;
        do_pop  = i_pop && o_valid;
        n_wptr  = do_push ? r_wptr + 1'b1 : r_wptr;
        n_rptr  = do_pop ? r_rptr + 1'b1 : r_rptr;
        n_count = r_count + QUEUE_CW'(do_push) - QUEUE_CW'(do_pop);
        o_job   = r_mem[r_rptr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

endmodule

`default_nettype wire

>>> src/b64e_back.sv
// ---------------------------------------------------------------------------
// Base64 encoder back end
// Serialises symbol jobs into ASCII characters through an output register.
// ---------------------------------------------------------------------------
`default_nettype none

module b64e_back
    import b64e_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_q_valid,
    input  t_job            i_q_job,
    output logic            o_q_pop,
    input  wire logic       i_pop,
    output logic            o_empty,
    output logic [7:0]      o_out_char,
    output logic            o_end_of_text
);

    t_job       r_job,   n_job;
    logic [1:0] r_idx,   n_idx;
    logic       r_busy,  n_busy;
    logic       r_ovld,  n_ovld;
    logic [7:0] r_ochar, n_ochar;
    logic       r_oend,  n_oend;
    logic       can_load, at_last, fetch;

    always_comb begin
        can_load = !r_ovld || i_pop;
        at_last  = (r_idx == r_job.last);
        fetch    = !r_busy || (can_load && at_last);
        o_q_pop  = fetch && i_q_valid;

        n_ovld  = r_ovld;
        n_ochar = r_ochar;
        n_oend  = r_oend;
        n_job   = r_job;
        n_idx   = r_idx;
        n_busy  = r_busy;

        if (can_load) begin
            n_ovld = r_busy;
            if (r_busy) begin
                n_ochar = sym_to_ascii(r_job.syms[r_idx]);
                n_oend  = at_last && r_job.fin;
            end
        end
        if (fetch) begin
            n_busy = i_q_valid;
            n_job  = i_q_job;
            n_idx  = 2'd0;
        end else if (can_load) begin
            n_idx = r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ovld <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_ovld <= n_ovld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job   <= n_job;
        r_idx   <= n_idx;
        r_ochar <= n_ochar;
        r_oend  <= n_oend;
    end

    assign o_empty       = !r_ovld;
    assign o_out_char    = r_ochar;
    assign o_end_of_text = r_oend;

endmodule

`default_nettype wire

>>> src/base64_stream_encoder_top.sv
// The first character of a byte passes through the job queue, the serialiser job register and the output register.
// One character per cycle on the result side while i_pop is held and jobs are
// queued; a byte yields 1 to 4 characters through the serialiser.
// A two-entry job queue lets input run ahead of a stalled result side.
// Reset: synchronous, active low; clears group phase, leftover bits and queue.
// ---------------------------------------------------------------------------
// Base64 stream encoder top level
// Byte stream in, standard base64 characters with '=' padding out.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module base64_stream_encoder_top
    import b64e_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_push,
    output logic            o_full,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_final_byte,
    output logic            o_empty,
    input  wire logic       i_pop,
    output logic [7:0]      o_out_char,
    output logic            o_end_of_text
);

    logic accept;
    t_job f_job;
    logic q_full, q_valid, q_pop;
    t_job q_job;
    logic out_take, pad_mid, pad_end;

    assign accept = i_push && !q_full;
    assign o_full = q_full;

    assign out_take = !o_empty && i_pop;
    assign pad_mid  = (o_out_char == CHAR_PAD) && !o_end_of_text;
    assign pad_end  = !o_empty && (o_out_char == CHAR_PAD) && o_end_of_text;

    b64e_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_data_byte  (i_data_byte),
        .i_final_byte (i_final_byte),
        .o_job        (f_job)
    );

    b64e_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_job   (f_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_job   (q_job)
    );

    b64e_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_q_job       (q_job),
        .o_q_pop       (q_pop),
        .i_pop         (i_pop),
        .o_empty       (o_empty),
        .o_out_char    (o_out_char),
        .o_end_of_text (o_end_of_text)
    );

    // final jobs always carry at least two characters
    `B64E_ASSERT_IMP(a_fin_job_len, i_clk, i_rst_n, q_valid && q_job.last == 2'd0, !q_job.fin)
    // a non-final pad is followed directly by the closing pad
    `B64E_ASSERT_NXT(a_pad_pair, i_clk, i_rst_n, out_take && pad_mid, pad_end)
    // no request taken while the queue is full
    `B64E_ASSERT_IMP(a_no_push_when_full_q, i_clk, i_rst_n, q_full, !accept)

endmodule

`default_nettype wire

>>> dv/tb_top.sv
// ---------------------------------------------------------------------------
// Base64 stream encoder testbench
// Sends byte messages through the push/full port and checks every character
// taken from the pop/empty port against a cycle-free model of the encoder.
// The run covers a directed set of padding and alphabet edge cases, random
// messages, random idling on both sides, one long receiver hold-off and a
// quiet tail.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_top
    import b64e_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT_CYCLES = 400000;
    localparam int TARGET_BYTES = 480;
    localparam int TAIL_BYTES   = 420;
    localparam int HOLD_CYCLES  = 150;
    localparam int SETTLE_CYCLES = 16;

    // {final, byte}
    localparam logic [8:0] DIRECTED [22] = '{
        {1'b1, 8'h00},
        {1'b1, 8'hFF},
        {1'b0, 8'h00}, {1'b1, 8'hFF},
        {1'b0, 8'hFF}, {1'b0, 8'h00}, {1'b1, 8'hFF},
        {1'b0, 8'hFF}, {1'b0, 8'hFF}, {1'b1, 8'hFF},
        {1'b0, 8'h4D}, {1'b0, 8'h61}, {1'b0, 8'h6E}, {1'b0, 8'hFC}, {1'b1, 8'h03},
        {1'b0, 8'hAA}, {1'b0, 8'h55}, {1'b0, 8'hAA}, {1'b1, 8'h55},
        {1'b0, 8'hFB}, {1'b0, 8'hEF}, {1'b1, 8'hBE}
    };

    class b64e_scoreboard;
        typedef struct {
            logic [7:0] ch;
            logic       eot;
        } t_char_exp;

        string       alphabet;
        t_phase      grp_phase;
        logic [3:0]  carry_bits;
        t_char_exp   expected_chars[$];
        int          n_errors;
        int          n_checked;
        int          n_bytes;
        int          n_messages;
        int          fin_at_phase[3];

        function new();
            alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
            grp_phase = PH_0;
            carry_bits = 4'd0;
            n_errors = 0;
            n_checked = 0;
            n_bytes = 0;
            n_messages = 0;
            foreach (fin_at_phase[k]) fin_at_phase[k] = 0;
        endfunction

        function void add_char(logic [7:0] ch, logic eot);
            t_char_exp e;
            e.ch = ch;
            e.eot = eot;
            expected_chars.push_back(e);
        endfunction

        function void add_sym(logic [5:0] six, logic eot);
            add_char(alphabet[six], eot);
        endfunction

        function int pending();
            return expected_chars.size();
        endfunction

        function void note_byte(logic [7:0] b, logic fin);
            t_phase ph_in;
            ph_in = grp_phase;
            n_bytes++;
            case (grp_phase)
                PH_1: begin
                    add_sym({carry_bits[1:0], b[7:4]}, 1'b0);
                    if (fin) begin
                        add_sym({b[3:0], 2'b00}, 1'b0);
                        add_char(CHAR_PAD, 1'b1);
                    end else begin
                        carry_bits = b[3:0];
                        grp_phase = PH_2;
                    end
                end
                PH_2: begin
                    add_sym({carry_bits, b[7:6]}, 1'b0);
                    add_sym(b[5:0], fin);
                    carry_bits = 4'd0;
                    grp_phase = PH_0;
                end
                default: begin
                    add_sym(b[7:2], 1'b0);
                    if (fin) begin
                        add_sym({b[1:0], 4'b0000}, 1'b0);
                        add_char(CHAR_PAD, 1'b0);
                        add_char(CHAR_PAD, 1'b1);
                    end else begin
                        carry_bits = {2'b00, b[1:0]};
                        grp_phase = PH_1;
                    end
                end
            endcase
            if (fin) begin
                fin_at_phase[(ph_in == PH_2) ? 2 : (ph_in == PH_1) ? 1 : 0]++;
                n_messages++;
                grp_phase = PH_0;
                carry_bits = 4'd0;
            end
        endfunction

        function void check_char(logic [7:0] ch, logic eot);
            t_char_exp e;
            n_checked++;
            if (expected_chars.size() == 0) begin
                $display("%0t: unexpected character, expected none, got %h end %b",
                         $time, ch, eot);
                n_errors++;
            end else begin
                e = expected_chars.pop_front();
                if (ch !== e.ch) begin
                    $display("%0t: out_char expected %h got %h", $time, e.ch, ch);
                    n_errors++;
                end
                if (eot !== e.eot) begin
                    $display("%0t: end_of_text expected %b got %b", $time, e.eot, eot);
                    n_errors++;
                end
            end
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       i_push;
    logic       o_full;
    logic [7:0] i_data_byte;
    logic       i_final_byte;
    logic       o_empty;
    logic       i_pop;
    logic [7:0] o_out_char;
    logic       o_end_of_text;

    b64e_scoreboard sb;
    int  cycles;
    int  hold_left;
    bit  no_idle;

    base64_stream_encoder_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (i_push),
        .o_full        (o_full),
        .i_data_byte   (i_data_byte),
        .i_final_byte  (i_final_byte),
        .o_empty       (o_empty),
        .i_pop         (i_pop),
        .o_out_char    (o_out_char),
        .o_end_of_text (o_end_of_text)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_pop && !o_empty) begin
            sb.check_char(o_out_char, o_end_of_text);
        end
    end

    // result side: random stalls, one long hold-off on request
    initial begin
        int stall;
        stall = 0;
        i_pop = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                i_pop <= 1'b0;
            end else if (no_idle) begin
                i_pop <= 1'b1;
            end else if (stall > 0) begin
                stall--;
                i_pop <= 1'b0;
            end else if ($urandom_range(0, 5) == 0) begin
                stall = $urandom_range(0, 9);
                i_pop <= 1'b0;
            end else begin
                i_pop <= 1'b1;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic fin);
        int n;
        if (!no_idle && $urandom_range(0, 4) == 0) begin
            n = $urandom_range(1, 10);
            @(negedge i_clk);
            i_push <= 1'b0;
            repeat (n - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_push <= 1'b1;
        i_data_byte <= b;
        i_final_byte <= fin;
        do @(posedge i_clk); while (o_full);
        sb.note_byte(b, fin);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_push <= 1'b0;
        while (sb.pending() > 0) @(posedge i_clk);
    endtask

    task automatic send_random_message();
        int len;
        int r;
        logic [7:0] b;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 24) : $urandom_range(1, 6);
        for (int k = 0; k < len; k++) begin
            r = $urandom_range(0, 15);
            b = (r == 0) ? 8'h00 : (r == 1) ? 8'hFF : 8'($urandom_range(0, 255));
            if (sb.n_bytes >= TAIL_BYTES) no_idle = 1'b1;
            send_byte(b, k == len - 1);
        end
    endtask

    initial begin
        bit paused;
        sb = new();
        cycles = 0;
        hold_left = 0;
        no_idle = 1'b0;
        paused = 1'b0;
        i_rst_n = 1'b0;
        i_push = 1'b0;
        i_data_byte = 8'h00;
        i_final_byte = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED[k]) send_byte(DIRECTED[k][7:0], DIRECTED[k][8]);
        wait_drained();

        // long hold-off on the result side while bytes keep coming
        hold_left = HOLD_CYCLES;
        while (sb.n_bytes < TARGET_BYTES) begin
            send_random_message();
            if (!paused && sb.n_bytes >= TARGET_BYTES / 2) begin
                paused = 1'b1;
                wait_drained();
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Encoded %0d bytes in %0d messages", sb.n_bytes, sb.n_messages);
        $display("Final byte at group position 0/1/2: %0d/%0d/%0d",
                 sb.fin_at_phase[0], sb.fin_at_phase[1], sb.fin_at_phase[2]);
        $display("Compared %0d characters, %0d mismatches", sb.n_checked, sb.n_errors);
        if (sb.n_errors == 0 && sb.pending() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
